FILE: src/mqck_pkg.sv
// Package for the MQTT client receive and keepalive block.
// Holds the item types, parser phase codes, event codes and packet types.
`timescale 1ns / 1ps
`default_nettype none
package mqck_pkg;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] rx_byte;
  } mqck_in_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [7:0]  out_byte;
    logic [15:0] message_id;
    logic [3:0]  packet_type;
    logic        last;
  } mqck_out_t;

  typedef enum logic [7:0] {
    PH_HDR   = 8'b0000_0001,
    PH_LEN   = 8'b0000_0010,
    PH_TLH   = 8'b0000_0100,
    PH_TLL   = 8'b0000_1000,
    PH_TOPIC = 8'b0001_0000,
    PH_MIDH  = 8'b0010_0000,
    PH_MIDL  = 8'b0100_0000,
    PH_BODY  = 8'b1000_0000
  } mqck_phase_t;

  localparam logic [2:0] K_BYTE = 3'd0;
  localparam logic [2:0] K_TICK = 3'd1;
  localparam logic [2:0] K_SENT = 3'd2;
  localparam logic [2:0] K_OPEN = 3'd3;
  localparam logic [2:0] K_LOST = 3'd4;

  localparam logic [3:0] EV_TOPIC    = 4'd1;
  localparam logic [3:0] EV_PAYLOAD  = 4'd2;
  localparam logic [3:0] EV_PUB_END  = 4'd3;
  localparam logic [3:0] EV_PUBACK   = 4'd4;
  localparam logic [3:0] EV_PINGRESP = 4'd5;
  localparam logic [3:0] EV_PONG     = 4'd6;
  localparam logic [3:0] EV_PINGREQ  = 4'd7;
  localparam logic [3:0] EV_TIMEOUT  = 4'd8;
  localparam logic [3:0] EV_DROPPED  = 4'd9;
  localparam logic [3:0] EV_CONN_OK  = 4'd10;
  localparam logic [3:0] EV_CONN_REF = 4'd11;

  localparam logic [3:0] T_CONNACK  = 4'h2;
  localparam logic [3:0] T_PUBLISH  = 4'h3;
  localparam logic [3:0] T_PINGREQ  = 4'hC;
  localparam logic [3:0] T_PINGRESP = 4'hD;

  localparam logic [26:0] CNT_MAX = 27'h7FF_FFFF;
  localparam logic [2:0]  REG_KEEPALIVE = 3'd0;

endpackage
`default_nettype wire

FILE: src/mqtt_client_receive_keepalive.sv
// Results of an accepted item go into an eight-entry result queue as it is taken.
// Throughput: one item per cycle; results leave one per cycle unless out_stall is
// high, and input stalls when fewer than three queue slots are free.
// An item gives up to three results. Reset is synchronous, active low, and
// clears parser, timers, session flag and queue; keepalive returns to 15 s.
`timescale 1ns / 1ps
`default_nettype none
module mqtt_client_receive_keepalive import mqck_pkg::*; #(
  parameter int MAX_PACKET = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire mqck_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output mqck_out_t        out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int DEPTH = 8;

  logic [15:0]  keepalive_r;
  mqck_phase_t  phase_r, phase_nxt;
  logic [7:0]   header_r, header_nxt;
  logic [15:0]  rlen_r, rlen_nxt;
  logic [2:0]   lbc_r, lbc_nxt;
  logic [15:0]  body_r, body_nxt;
  logic [15:0]  tlen_r, tlen_nxt;
  logic [15:0]  msgid_r, msgid_nxt;
  logic         disc_r, disc_nxt;
  logic [7:0]   conn_r, conn_nxt;
  logic [26:0]  ms_in_r, ms_in_nxt;
  logic [26:0]  ms_out_r, ms_out_nxt;
  logic         ping_r, ping_nxt;
  logic         sess_r, sess_nxt;

  mqck_out_t    fifo_r [DEPTH];
  logic [2:0]   head_r, tail_r;
  logic [3:0]   count_r;
  mqck_out_t    res_v [3];
  logic [1:0]   n_v;
  logic         accept, pop;
  logic [26:0]  limit;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 3'd0) ? {16'd0, keepalive_r} : 32'd0;
  assign limit      = 27'(keepalive_r * 27'd1000);
  assign in_stall   = count_r > 4'(DEPTH - 3);
  assign accept     = in_valid && !in_stall;
  assign out_valid  = count_r != 4'd0;
  assign out_data   = fifo_r[head_r];
  assign pop        = out_valid && !out_stall;

  function automatic mqck_out_t mk(input logic [3:0] ev, input logic [7:0] b,
                                   input logic [15:0] id, input logic [7:0] hdr);
    mqck_out_t r;
    r.event_res   = ev;
    r.out_byte    = b;
    r.message_id  = id;
    r.packet_type = hdr[7:4];
    r.last        = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [27:0] shifted;
    logic [27:0] v;
    logic [17:0] total;
    logic [17:0] need;
    logic        pub, qos1;
    logic [3:0]  ptype;
    phase_nxt  = phase_r;
    header_nxt = header_r;
    rlen_nxt   = rlen_r;
    lbc_nxt    = lbc_r;
    body_nxt   = body_r;
    tlen_nxt   = tlen_r;
    msgid_nxt  = msgid_r;
    disc_nxt   = disc_r;
    conn_nxt   = conn_r;
    ms_in_nxt  = ms_in_r;
    ms_out_nxt = ms_out_r;
    ping_nxt   = ping_r;
    sess_nxt   = sess_r;
    n_v        = 2'd0;
    for (int i = 0; i < 3; i++) res_v[i] = mk(4'd0, 8'd0, 16'd0, header_r);
    pub     = header_r[7:4] == T_PUBLISH;
    qos1    = (header_r[2:1]) == 2'b01;
    ptype   = header_r[7:4];
    shifted = 28'(in_data.rx_byte[6:0]) << (7 * lbc_r[1:0]);
    v       = 28'(rlen_r) + shifted;
    total   = 18'd0;
    need    = 18'd0;
    case (in_data.kind)
      K_BYTE: begin
        if (sess_r) begin
          if (phase_r == PH_HDR) begin
            header_nxt = in_data.rx_byte;
            rlen_nxt   = 16'd0;
            lbc_nxt    = 3'd0;
            body_nxt   = 16'd0;
            tlen_nxt   = 16'd0;
            msgid_nxt  = 16'd0;
            conn_nxt   = 8'd0;
            disc_nxt   = 1'b0;
            phase_nxt  = PH_LEN;
          end else if (phase_r == PH_LEN) begin
            rlen_nxt = (v > 28'hFFFF) ? 16'hFFFF : v[15:0];
            lbc_nxt  = lbc_r + 3'd1;
            total    = 18'd1 + 18'(lbc_nxt) + 18'(rlen_nxt);
            if (in_data.rx_byte[7]) begin
              if (lbc_nxt >= 3'd4) begin
                res_v[n_v] = mk(EV_DROPPED, 8'd0, 16'd0, header_r);
                n_v        = n_v + 2'd1;
                phase_nxt  = PH_HDR;
                disc_nxt   = 1'b0;
              end
            end else if (total > 18'(MAX_PACKET) || (pub && rlen_nxt < 16'd2)) begin
              res_v[n_v] = mk(EV_DROPPED, 8'd0, 16'd0, header_r);
              n_v        = n_v + 2'd1;
              disc_nxt   = 1'b1;
              phase_nxt  = (rlen_nxt == 16'd0) ? PH_HDR : PH_BODY;
            end else if (pub) begin
              phase_nxt = PH_TLH;
            end else if (rlen_nxt == 16'd0) begin
              ms_in_nxt = 27'd0;
              phase_nxt = PH_HDR;
              if (ptype == T_PINGREQ) begin
                res_v[n_v] = mk(EV_PINGRESP, 8'd0, 16'd0, header_r);
                n_v        = n_v + 2'd1;
              end else if (ptype == T_PINGRESP) begin
                ping_nxt   = 1'b0;
                res_v[n_v] = mk(EV_PONG, 8'd0, 16'd0, header_r);
                n_v        = n_v + 2'd1;
              end else if (ptype == T_CONNACK) begin
                sess_nxt   = 1'b0;
                res_v[n_v] = mk(EV_CONN_REF, 8'd0, 16'd0, header_r);
                n_v        = n_v + 2'd1;
              end
            end else begin
              phase_nxt = PH_BODY;
            end
          end else begin
            body_nxt = body_r + 16'd1;
            case (phase_r)
              PH_TLH: begin
                tlen_nxt  = {in_data.rx_byte, 8'd0};
                phase_nxt = PH_TLL;
              end
              PH_TLL: begin
                tlen_nxt = tlen_r | 16'(in_data.rx_byte);
                need     = 18'd2 + 18'(tlen_nxt) + (qos1 ? 18'd2 : 18'd0);
                if (need > 18'(rlen_r)) begin
                  res_v[n_v] = mk(EV_DROPPED, 8'd0, 16'd0, header_r);
                  n_v        = n_v + 2'd1;
                  disc_nxt   = 1'b1;
                  phase_nxt  = PH_BODY;
                end else if (tlen_nxt != 16'd0) begin
                  phase_nxt = PH_TOPIC;
                end else begin
                  phase_nxt = qos1 ? PH_MIDH : PH_BODY;
                end
              end
              PH_TOPIC: begin
                res_v[n_v] = mk(EV_TOPIC, in_data.rx_byte, 16'd0, header_r);
                n_v        = n_v + 2'd1;
                if (17'(body_nxt) >= 17'd2 + 17'(tlen_r))
                  phase_nxt = qos1 ? PH_MIDH : PH_BODY;
              end
              PH_MIDH: begin
                msgid_nxt = {in_data.rx_byte, 8'd0};
                phase_nxt = PH_MIDL;
              end
              PH_MIDL: begin
                msgid_nxt = msgid_r | 16'(in_data.rx_byte);
                phase_nxt = PH_BODY;
              end
              default: begin
                if (!disc_r) begin
                  if (pub) begin
                    res_v[n_v] = mk(EV_PAYLOAD, in_data.rx_byte, 16'd0, header_r);
                    n_v        = n_v + 2'd1;
                  end else if (body_nxt == 16'd2) begin
                    conn_nxt = in_data.rx_byte;
                  end
                end
              end
            endcase
            if (body_nxt >= rlen_r) begin
              if (!disc_nxt) begin
                ms_in_nxt = 27'd0;
                if (pub) begin
                  res_v[n_v] = mk(EV_PUB_END, 8'd0, 16'd0, header_r);
                  n_v        = n_v + 2'd1;
                  if (qos1) begin
                    res_v[n_v] = mk(EV_PUBACK, 8'd0, msgid_nxt, header_r);
                    n_v        = n_v + 2'd1;
                    ms_out_nxt = 27'd0;
                  end
                end else if (ptype == T_PINGREQ) begin
                  res_v[n_v] = mk(EV_PINGRESP, 8'd0, 16'd0, header_r);
                  n_v        = n_v + 2'd1;
                end else if (ptype == T_PINGRESP) begin
                  ping_nxt   = 1'b0;
                  res_v[n_v] = mk(EV_PONG, 8'd0, 16'd0, header_r);
                  n_v        = n_v + 2'd1;
                end else if (ptype == T_CONNACK) begin
                  if (rlen_r == 16'd2 && conn_nxt == 8'd0) begin
                    ping_nxt   = 1'b0;
                    res_v[n_v] = mk(EV_CONN_OK, 8'd0, 16'd0, header_r);
                  end else begin
                    sess_nxt   = 1'b0;
                    res_v[n_v] = mk(EV_CONN_REF, 8'd0, 16'd0, header_r);
                  end
                  n_v = n_v + 2'd1;
                end
              end
              phase_nxt = PH_HDR;
              disc_nxt  = 1'b0;
            end
          end
        end
      end
      K_TICK: begin
        if (sess_r) begin
          if (ms_in_r < CNT_MAX) ms_in_nxt = ms_in_r + 27'd1;
          if (ms_out_r < CNT_MAX) ms_out_nxt = ms_out_r + 27'd1;
          if (ms_in_nxt > limit || ms_out_nxt > limit) begin
            if (ping_r) begin
              res_v[n_v] = mk(EV_TIMEOUT, 8'd0, 16'd0, header_r);
              sess_nxt   = 1'b0;
              phase_nxt  = PH_HDR;
              disc_nxt   = 1'b0;
            end else begin
              res_v[n_v] = mk(EV_PINGREQ, 8'd0, 16'd0, header_r);
              ms_in_nxt  = 27'd0;
              ms_out_nxt = 27'd0;
              ping_nxt   = 1'b1;
            end
            n_v = n_v + 2'd1;
          end
        end
      end
      K_SENT: ms_out_nxt = 27'd0;
      K_OPEN: begin
        phase_nxt  = PH_HDR;
        disc_nxt   = 1'b0;
        ms_in_nxt  = 27'd0;
        ms_out_nxt = 27'd0;
        ping_nxt   = 1'b0;
        sess_nxt   = 1'b1;
      end
      K_LOST: begin
        sess_nxt  = 1'b0;
        phase_nxt = PH_HDR;
        disc_nxt  = 1'b0;
      end
      default: ;
    endcase
    if (n_v != 2'd0) res_v[n_v - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keepalive_r <= 16'd15;
      phase_r     <= PH_HDR;
      header_r    <= 8'd0;
      rlen_r      <= 16'd0;
      lbc_r       <= 3'd0;
      body_r      <= 16'd0;
      tlen_r      <= 16'd0;
      msgid_r     <= 16'd0;
      disc_r      <= 1'b0;
      conn_r      <= 8'd0;
      ms_in_r     <= 27'd0;
      ms_out_r    <= 27'd0;
      ping_r      <= 1'b0;
      sess_r      <= 1'b0;
      head_r      <= 3'd0;
      tail_r      <= 3'd0;
      count_r     <= 4'd0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_KEEPALIVE)
        keepalive_r <= cfg_pwdata[15:0];
      if (accept) begin
        phase_r  <= phase_nxt;
        header_r <= header_nxt;
        rlen_r   <= rlen_nxt;
        lbc_r    <= lbc_nxt;
        body_r   <= body_nxt;
        tlen_r   <= tlen_nxt;
        msgid_r  <= msgid_nxt;
        disc_r   <= disc_nxt;
        conn_r   <= conn_nxt;
        ms_in_r  <= ms_in_nxt;
        ms_out_r <= ms_out_nxt;
        ping_r   <= ping_nxt;
        sess_r   <= sess_nxt;
        tail_r   <= tail_r + 3'(n_v);
      end
      if (pop) head_r <= head_r + 3'd1;
      count_r <= count_r + (accept ? 4'(n_v) : 4'd0) - (pop ? 4'd1 : 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < n_v) fifo_r[tail_r + 3'(i)] <= res_v[i];
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/mqck_checker.sv
// Checker for the MQTT client receive and keepalive block.
// Watches both channels and the config port, predicts results and compares them.
// Depends on mqck_pkg.
`timescale 1ns / 1ps
module mqck_checker import mqck_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire mqck_in_t    in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire mqck_out_t   out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               fails,
  output int               pending,
  output int               n_events
);
  localparam int MAXPKT = 128;

  mqck_out_t   due_q[$];
  mqck_out_t   step_q[$];
  logic [15:0] ka;
  mqck_phase_t ph;
  logic [7:0]  hdr;
  logic [15:0] rlen;
  logic [2:0]  lcnt;
  logic [15:0] bcnt;
  logic [15:0] tlen;
  logic [15:0] mid;
  logic        disc;
  logic [7:0]  ccode;
  logic [26:0] t_in;
  logic [26:0] t_out;
  logic        ping_out;
  logic        up;

  function automatic logic is_pub();
    return hdr[7:4] == T_PUBLISH;
  endfunction

  function automatic logic is_q1();
    return (hdr & 8'h06) == 8'h02;
  endfunction

  task automatic push(input logic [3:0] ev, input logic [7:0] b, input logic [15:0] id);
    mqck_out_t r;
    r.event_res = ev;
    r.out_byte = b;
    r.message_id = id;
    r.packet_type = hdr[7:4];
    r.last = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic park();
    ph = PH_HDR;
    disc = 1'b0;
  endtask

  task automatic close_other();
    if (hdr[7:4] == T_PINGREQ) begin
      push(EV_PINGRESP, 0, 0);
    end else if (hdr[7:4] == T_PINGRESP) begin
      ping_out = 1'b0;
      push(EV_PONG, 0, 0);
    end else if (hdr[7:4] == T_CONNACK) begin
      if (rlen == 16'd2 && ccode == 8'd0) begin
        ping_out = 1'b0;
        push(EV_CONN_OK, 0, 0);
      end else begin
        up = 1'b0;
        push(EV_CONN_REF, 0, 0);
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    int unsigned v;
    int unsigned need;
    if (ph == PH_HDR) begin
      hdr = b;
      rlen = 0;
      lcnt = 0;
      bcnt = 0;
      tlen = 0;
      mid = 0;
      ccode = 0;
      disc = 1'b0;
      ph = PH_LEN;
      return;
    end
    if (ph == PH_LEN) begin
      v = int'(rlen) + (int'(b[6:0]) << (7 * int'(lcnt[1:0])));
      rlen = (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
      lcnt = lcnt + 3'd1;
      if (b[7]) begin
        if (lcnt >= 3'd4) begin
          push(EV_DROPPED, 0, 0);
          park();
        end
        return;
      end
      if (1 + int'(lcnt) + int'(rlen) > MAXPKT || (is_pub() && rlen < 16'd2)) begin
        push(EV_DROPPED, 0, 0);
        disc = 1'b1;
        ph = (rlen == 0) ? PH_HDR : PH_BODY;
      end else if (is_pub()) begin
        ph = PH_TLH;
      end else if (rlen == 0) begin
        t_in = 0;
        ph = PH_HDR;
        close_other();
      end else begin
        ph = PH_BODY;
      end
      return;
    end
    bcnt = bcnt + 16'd1;
    case (ph)
      PH_TLH: begin
        tlen = {b, 8'h00};
        ph = PH_TLL;
      end
      PH_TLL: begin
        tlen[7:0] = b;
        need = 2 + int'(tlen) + (is_q1() ? 2 : 0);
        if (need > int'(rlen)) begin
          push(EV_DROPPED, 0, 0);
          disc = 1'b1;
          ph = PH_BODY;
        end else if (tlen != 0) begin
          ph = PH_TOPIC;
        end else begin
          ph = is_q1() ? PH_MIDH : PH_BODY;
        end
      end
      PH_TOPIC: begin
        push(EV_TOPIC, b, 0);
        if (int'(bcnt) >= 2 + int'(tlen)) ph = is_q1() ? PH_MIDH : PH_BODY;
      end
      PH_MIDH: begin
        mid = {b, 8'h00};
        ph = PH_MIDL;
      end
      PH_MIDL: begin
        mid[7:0] = b;
        ph = PH_BODY;
      end
      default: begin
        if (!disc) begin
          if (is_pub()) push(EV_PAYLOAD, b, 0);
          else if (bcnt == 16'd2) ccode = b;
        end
      end
    endcase
    if (bcnt >= rlen) begin
      if (!disc) begin
        t_in = 0;
        if (is_pub()) begin
          push(EV_PUB_END, 0, 0);
          if (is_q1()) begin
            push(EV_PUBACK, 0, mid);
            t_out = 0;
          end
        end else begin
          close_other();
        end
      end
      park();
    end
  endtask

  task automatic take_tick();
    int unsigned lim;
    lim = int'(ka) * 1000;
    if (t_in < CNT_MAX) t_in = t_in + 27'd1;
    if (t_out < CNT_MAX) t_out = t_out + 27'd1;
    if (int'(t_in) > lim || int'(t_out) > lim) begin
      if (ping_out) begin
        push(EV_TIMEOUT, 0, 0);
        up = 1'b0;
        park();
      end else begin
        push(EV_PINGREQ, 0, 0);
        t_in = 0;
        t_out = 0;
        ping_out = 1'b1;
      end
    end
  endtask

  task automatic predict_item(input mqck_in_t it);
    step_q.delete();
    case (it.kind)
      K_BYTE: if (up) take_byte(it.rx_byte);
      K_TICK: if (up) take_tick();
      K_SENT: t_out = 0;
      K_OPEN: begin
        park();
        t_in = 0;
        t_out = 0;
        ping_out = 1'b0;
        up = 1'b1;
      end
      K_LOST: begin
        up = 1'b0;
        park();
      end
      default: ;
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) due_q.push_back(step_q[i]);
  endtask

  always @(posedge clk) begin
    mqck_out_t e;
    if (!rst_n) begin
      due_q.delete();
      ka = 16'd15;
      ph = PH_HDR;
      hdr = 0;
      rlen = 0;
      lcnt = 0;
      bcnt = 0;
      tlen = 0;
      mid = 0;
      disc = 0;
      ccode = 0;
      t_in = 0;
      t_out = 0;
      ping_out = 0;
      up = 0;
      fails = 0;
      n_events = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $error("unexpected result item event_res=%0d", out_data.event_res);
          fails = fails + 1;
        end else begin
          e = due_q.pop_front();
          n_events = n_events + 1;
          if (out_data.event_res !== e.event_res) begin
            $error("event_res expected %0d got %0d", e.event_res, out_data.event_res);
            fails = fails + 1;
          end
          if (out_data.out_byte !== e.out_byte) begin
            $error("out_byte expected %0h got %0h", e.out_byte, out_data.out_byte);
            fails = fails + 1;
          end
          if (out_data.message_id !== e.message_id) begin
            $error("message_id expected %0h got %0h", e.message_id, out_data.message_id);
            fails = fails + 1;
          end
          if (out_data.packet_type !== e.packet_type) begin
            $error("packet_type expected %0h got %0h", e.packet_type, out_data.packet_type);
            fails = fails + 1;
          end
          if (out_data.last !== e.last) begin
            $error("last expected %0b got %0b", e.last, out_data.last);
            fails = fails + 1;
          end
        end
      end
      if (in_valid && !in_stall) predict_item(in_data);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == 3'd0)
        ka = cfg_pwdata[15:0];
    end
    pending = due_q.size();
  end
endmodule

FILE: tb/tb_mqtt_client_receive_keepalive.sv
// Top of the testbench for the MQTT client receive and keepalive block.
// Drives packets, ticks and session notices, sets keepalive, and gives the verdict.
// Depends on mqck_pkg, mqtt_client_receive_keepalive and mqck_checker.
`timescale 1ns / 1ps
module tb_mqtt_client_receive_keepalive;
  import mqck_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  mqck_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  mqck_out_t   out_data;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fails;
  int          pending;
  int          n_events;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_len = 0;
  int          n_items = 0;
  int          quiet = 0;

  always #5 clk = ~clk;

  mqtt_client_receive_keepalive uut (.*);

  mqck_checker chk (.*);

  always @(posedge clk) begin
    if (hold_len > 0) begin
      hold_len <= hold_len - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(input logic [2:0] k, input logic [7:0] b);
    mqck_in_t d;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    d.kind = k;
    d.rx_byte = b;
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    n_items++;
  endtask

  task automatic settle_and_write(input logic [15:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= REG_KEEPALIVE;
    cfg_pwdata <= {16'($urandom_range(65535)), v};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send_len(input int n);
    if (n < 128) begin
      send(K_BYTE, n[7:0]);
    end else begin
      send(K_BYTE, {1'b1, n[6:0]});
      send(K_BYTE, {1'b0, n[13:7]});
    end
  endtask

  task automatic send_pub(input logic [3:0] flags, input int tl, input int pl, input int slack);
    int q1;
    int rl;
    q1 = ((flags & 4'h6) == 4'h2);
    rl = 2 + tl + (q1 ? 2 : 0) + pl;
    send(K_BYTE, {T_PUBLISH, flags});
    send_len(rl);
    send(K_BYTE, 8'(((tl + slack) >> 8)));
    send(K_BYTE, 8'(tl + slack));
    repeat (tl + (q1 ? 2 : 0) + pl) send(K_BYTE, 8'($urandom_range(255)));
  endtask

  task automatic send_packet();
    int sel;
    int n;
    sel = $urandom_range(99);
    if (sel < 45) begin
      send_pub(4'($urandom_range(15)), $urandom_range(4), $urandom_range(5), 0);
    end else if (sel < 52) begin
      send_pub(4'($urandom_range(15)), $urandom_range(3), $urandom_range(2), 1 + $urandom_range(2));
    end else if (sel < 60) begin
      send(K_BYTE, {T_PINGREQ, 4'($urandom_range(15))});
      send(K_BYTE, 8'd0);
    end else if (sel < 66) begin
      send(K_BYTE, {T_PINGRESP, 4'h0});
      send(K_BYTE, 8'd0);
    end else if (sel < 76) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(3) : 2;
      send(K_BYTE, {T_CONNACK, 4'h0});
      send(K_BYTE, n[7:0]);
      repeat (n) send(K_BYTE, ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255)));
    end else if (sel < 84) begin
      n = $urandom_range(4);
      send(K_BYTE, 8'($urandom_range(255)));
      send(K_BYTE, n[7:0]);
      repeat (n) send(K_BYTE, 8'($urandom_range(255)));
    end else if (sel < 88) begin
      send(K_BYTE, {T_PUBLISH, 4'h0});
      send(K_BYTE, 8'($urandom_range(1)));
    end else if (sel < 91) begin
      n = 126 + $urandom_range(8);
      send(K_BYTE, {4'($urandom_range(15)), 4'h0});
      send_len(n);
      repeat (n) send(K_BYTE, 8'($urandom_range(255)));
    end else if (sel < 94) begin
      send(K_BYTE, 8'($urandom_range(255)));
      repeat (4) send(K_BYTE, 8'h80 | 8'($urandom_range(127)));
    end else begin
      repeat (1 + $urandom_range(3)) send(3'($urandom_range(7)), 8'($urandom_range(255)));
      send(K_OPEN, 8'($urandom_range(255)));
    end
    if ($urandom_range(3) == 0) send(K_TICK, 8'($urandom_range(255)));
    if ($urandom_range(7) == 0) send(K_SENT, 8'($urandom_range(255)));
  endtask

  initial begin
    int ph_items;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    settle_and_write(16'd0);
    send(K_BYTE, 8'h30);
    send(K_TICK, 8'h00);
    send(K_OPEN, 8'h00);
    send_pub(4'h2, 2, 1, 0);
    send_pub(4'h0, 0, 0, 0);
    send(K_BYTE, 8'hC0);
    send(K_BYTE, 8'h00);
    send(K_BYTE, 8'h20);
    send(K_BYTE, 8'h02);
    send(K_BYTE, 8'h00);
    send(K_BYTE, 8'h00);
    send(K_BYTE, 8'hFF);
    send(K_BYTE, 8'hFF);
    send(K_BYTE, 8'hFF);
    send(K_BYTE, 8'hFF);
    send(K_BYTE, 8'h7F);
    send(K_LOST, 8'h00);
    send(K_OPEN, 8'h00);
    send(3'd7, 8'hFF);
    repeat (2) send(K_TICK, 8'h00);
    send(K_SENT, 8'h00);
    send(K_OPEN, 8'h00);
    repeat (3) send(K_TICK, 8'h00);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  settle_and_write(16'd65535); end
        1: begin idle_pct = 74; stall_pct = 0;  settle_and_write(16'd2); end
        2: begin idle_pct = 0;  stall_pct = 74; settle_and_write(16'($urandom_range(65535))); end
        default: begin idle_pct = 38; stall_pct = 38; settle_and_write(16'd1); end
      endcase
      send(K_OPEN, 8'h00);
      if (p == 0) hold_len = 300;
      ph_items = n_items;
      while (n_items - ph_items < 90) send_packet();
    end

    in_valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Drove %0d items across four pacing phases and five keepalive settings;",
             n_items);
    $display("checked %0d result items covering publish, ping, connack, drops and timers.",
             n_events);
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
src/mqck_pkg.sv
src/mqtt_client_receive_keepalive.sv
tb/mqck_checker.sv
tb/tb_mqtt_client_receive_keepalive.sv
